// ===== hw/rtl/npd_pkg.sv =====
// npd_pkg: packet layout constants, integrity and suffix codes, and the
// hamming 8/4 prefix decoder used by the decoder.
// No dependencies.
package npd_pkg;

    localparam int PREFIX_BYTES = 5;
    localparam int BLOCK_BYTES  = 28;
    localparam int PACKET_BYTES = PREFIX_BYTES + BLOCK_BYTES;
    localparam int IDX_W        = $clog2(BLOCK_BYTES);
    localparam int CNT_W        = $clog2(PACKET_BYTES);

    localparam logic [7:0] SYN_MASK = 8'hFF;

    typedef enum logic [1:0] {
        INTEG_UNCHECKED     = 2'd0,
        INTEG_CLEAN         = 2'd1,
        INTEG_CORRECTED     = 2'd2,
        INTEG_UNCORRECTABLE = 2'd3
    } t_integrity;

    typedef enum logic [1:0] {
        SUFFIX_NONE     = 2'd0,
        SUFFIX_LONG     = 2'd1,
        SUFFIX_LONG_RES = 2'd2,
        SUFFIX_BUNDLE   = 2'd3
    } t_suffix;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_ham;

    function automatic logic odd_parity(input logic [7:0] b);
        return ^b;
    endfunction

    // data bits at 1,3,5,7; single errors corrected, double errors flagged
    function automatic t_ham ham84(input logic [7:0] b);
        logic [2:0] pat;
        logic [3:0] d;
        t_ham       r;
        d      = {b[7], b[5], b[3], b[1]};
        pat[2] = ~(b[0] ^ b[1] ^ b[5] ^ b[7]);
        pat[1] = ~(b[2] ^ b[1] ^ b[3] ^ b[7]);
        pat[0] = ~(b[4] ^ b[1] ^ b[3] ^ b[5]);
        r.ok   = 1'b1;
        if (pat != 3'd0) begin
            if (odd_parity(b)) begin
                r.ok = 1'b0;
            end else begin
                case (pat)
                    3'd7:    d[0] = ~d[0];
                    3'd3:    d[1] = ~d[1];
                    3'd5:    d[2] = ~d[2];
                    3'd6:    d[3] = ~d[3];
                    default: d = d;
                endcase
            end
        end
        r.nib = d;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] block_len(input logic [1:0] kind);
        logic [IDX_W-1:0] n;
        case (kind)
            SUFFIX_NONE:     n = IDX_W'(BLOCK_BYTES);
            SUFFIX_LONG:     n = IDX_W'(BLOCK_BYTES - 1);
            SUFFIX_LONG_RES: n = IDX_W'(BLOCK_BYTES - 2);
            default:         n = '0;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/nabts_packet_decoder.sv =====
// nabts_packet_decoder: prefix decode, block buffering and longitudinal
// parity check and repair of nabts packets. Depends on npd_pkg.
//
// Bytes are taken one per cycle while a packet is received. The 28-byte
// block goes into a single-port buffer memory, with the running xor and the
// odd-parity failures tracked as it arrives. The 33rd byte starts the result
// run: input is stalled while the run is read back from the buffer, one
// result per cycle when the output is not stalled, through the buffer read
// register and then the output register. A full packet is 33 input bytes,
// then 26 to 28 results (one for a bad prefix or a bundle packet). Bytes
// outside a packet are taken and dropped; a start flag drops any unfinished
// packet.
module nabts_packet_decoder
    import npd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_raw_byte,
    input  logic        i_packet_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_packet_valid,
    output logic [11:0] o_channel,
    output logic [3:0]  o_continuity,
    output logic        o_synchronizing,
    output logic        o_partial_block,
    output logic [1:0]  o_suffix_kind,
    output logic [4:0]  o_block_length,
    output logic [1:0]  o_integrity,
    output logic        o_has_data,
    output logic [4:0]  o_byte_index,
    output logic [7:0]  o_block_byte,
    output logic        o_last
);

    typedef enum logic {ST_RECV, ST_EMIT} t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic             r_in_packet, n_in_packet;
    logic [11:0]      r_channel, n_channel;
    logic [3:0]       r_continuity, n_continuity;
    logic [3:0]       r_structure, n_structure;
    logic             r_prefix_error, n_prefix_error;
    logic [7:0]       r_running_xor, n_running_xor;
    logic [1:0]       r_fail_count, n_fail_count;
    logic [IDX_W-1:0] r_fail_pos, n_fail_pos;

    logic [7:0]       r_block_mem [BLOCK_BYTES];

    // read stage
    logic             r_rd_vld;
    logic [7:0]       r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_has;
    logic             r_rd_fix;
    logic             r_rd_last;
    logic [IDX_W-1:0] r_emit_idx;

    // output register
    logic             r_out_valid;
    logic             r_packet_valid;
    logic [11:0]      r_channel_o;
    logic [3:0]       r_continuity_o;
    logic             r_sync_o;
    logic             r_partial_o;
    logic [1:0]       r_kind_o;
    logic [4:0]       r_len_o;
    logic [1:0]       r_integ_o;
    logic             r_has_o;
    logic [4:0]       r_index_o;
    logic [7:0]       r_byte_o;
    logic             r_last_o;

    logic             in_take, out_take, rd_adv, issue;
    logic             pkt_open;
    logic [CNT_W-1:0] idx;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_en;
    t_ham             hd;
    logic [1:0]       kind;
    logic [IDX_W-1:0] len;
    logic [7:0]       syn;
    t_integrity       integ;
    logic [IDX_W-1:0] emit_n;
    logic             emit_last;

    assign o_in_stall = (r_state == ST_EMIT) || r_rd_vld;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = !r_out_valid || !i_out_stall;
    assign rd_adv     = r_rd_vld && out_take;
    assign issue      = (r_state == ST_EMIT) && (!r_rd_vld || out_take);

    assign pkt_open = i_packet_start || r_in_packet;
    assign idx      = i_packet_start ? '0 : r_byte_count;
    assign wr_idx   = IDX_W'(idx - CNT_W'(PREFIX_BYTES));
    assign wr_en    = in_take && pkt_open && (idx >= CNT_W'(PREFIX_BYTES));
    assign hd       = ham84(i_raw_byte);

    always_comb begin
        n_state        = r_state;
        n_byte_count   = r_byte_count;
        n_in_packet    = r_in_packet;
        n_channel      = r_channel;
        n_continuity   = r_continuity;
        n_structure    = r_structure;
        n_prefix_error = r_prefix_error;
        n_running_xor  = r_running_xor;
        n_fail_count   = r_fail_count;
        n_fail_pos     = r_fail_pos;
        if (in_take && i_packet_start) begin
            n_channel      = '0;
            n_continuity   = '0;
            n_structure    = '0;
            n_prefix_error = 1'b0;
            n_running_xor  = '0;
            n_fail_count   = '0;
            n_fail_pos     = '0;
        end
        if (in_take && pkt_open) begin
            if (idx < CNT_W'(PREFIX_BYTES)) begin
                if (!hd.ok) begin
                    n_prefix_error = 1'b1;
                end else begin
                    case (idx)
                        CNT_W'(0): n_channel = {hd.nib, 8'h00};
                        CNT_W'(1): n_channel = n_channel | {4'h0, hd.nib, 4'h0};
                        CNT_W'(2): n_channel = n_channel | {8'h00, hd.nib};
                        CNT_W'(3): n_continuity = hd.nib;
                        default:   n_structure = hd.nib;
                    endcase
                end
            end else begin
                n_running_xor = n_running_xor ^ i_raw_byte;
                if (!odd_parity(i_raw_byte)) begin
                    if (n_fail_count < 2'd2) begin
                        n_fail_count = n_fail_count + 2'd1;
                    end
                    n_fail_pos = wr_idx;
                end
            end
            if (idx == CNT_W'(PACKET_BYTES - 1)) begin
                n_byte_count = '0;
                n_in_packet  = 1'b0;
                n_state      = ST_EMIT;
            end else begin
                n_byte_count = idx + CNT_W'(1);
                n_in_packet  = 1'b1;
            end
        end
        // last read of the run issued, back to receiving
        if (issue && emit_last) begin
            n_state = ST_RECV;
        end
    end

    // per-packet results, stable while the run is out
    assign kind   = r_structure[3:2];
    assign len    = block_len(kind);
    assign syn    = r_running_xor ^ SYN_MASK;
    always_comb begin
        integ = INTEG_UNCHECKED;
        if (kind == SUFFIX_LONG || kind == SUFFIX_LONG_RES) begin
            if (syn == 8'h00) begin
                integ = INTEG_CLEAN;
            end else if ((syn & (syn - 8'd1)) != 8'h00 || r_fail_count != 2'd1) begin
                integ = INTEG_UNCORRECTABLE;
            end else begin
                integ = INTEG_CORRECTED;
            end
        end
    end
    assign emit_n    = (r_prefix_error || len == '0) ? IDX_W'(1) : len;
    assign emit_last = (r_emit_idx == emit_n - IDX_W'(1));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_block_mem[wr_idx] <= i_raw_byte;
        end
        if (issue) begin
            r_rd_data <= r_block_mem[r_emit_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_RECV;
            r_byte_count   <= '0;
            r_in_packet    <= 1'b0;
            r_channel      <= '0;
            r_continuity   <= '0;
            r_structure    <= '0;
            r_prefix_error <= 1'b0;
            r_running_xor  <= '0;
            r_fail_count   <= '0;
            r_fail_pos     <= '0;
            r_emit_idx     <= '0;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_byte_count   <= n_byte_count;
            r_in_packet    <= n_in_packet;
            r_channel      <= n_channel;
            r_continuity   <= n_continuity;
            r_structure    <= n_structure;
            r_prefix_error <= n_prefix_error;
            r_running_xor  <= n_running_xor;
            r_fail_count   <= n_fail_count;
            r_fail_pos     <= n_fail_pos;

            if (issue) begin
                r_rd_vld  <= 1'b1;
                r_rd_idx  <= r_emit_idx;
                r_rd_has  <= !r_prefix_error && (len != '0);
                r_rd_fix  <= (integ == INTEG_CORRECTED) && (r_emit_idx == r_fail_pos);
                r_rd_last <= emit_last;
                if (emit_last) begin
                    r_emit_idx <= '0;
                end else begin
                    r_emit_idx <= r_emit_idx + IDX_W'(1);
                end
            end else if (rd_adv) begin
                r_rd_vld <= 1'b0;
            end

            if (rd_adv) begin
                r_out_valid    <= 1'b1;
                r_packet_valid <= !r_prefix_error;
                r_last_o       <= r_rd_last;
                r_has_o        <= r_rd_has;
                r_index_o      <= r_rd_has ? 5'(r_rd_idx) : '0;
                r_byte_o       <= !r_rd_has ? 8'h00 :
                                  (r_rd_fix ? (r_rd_data ^ syn) : r_rd_data);
                if (r_prefix_error) begin
                    r_channel_o    <= '0;
                    r_continuity_o <= '0;
                    r_sync_o       <= 1'b0;
                    r_partial_o    <= 1'b0;
                    r_kind_o       <= '0;
                    r_len_o        <= '0;
                    r_integ_o      <= INTEG_UNCHECKED;
                end else begin
                    r_channel_o    <= r_channel;
                    r_continuity_o <= r_continuity;
                    r_sync_o       <= r_structure[0];
                    r_partial_o    <= r_structure[1];
                    r_kind_o       <= kind;
                    r_len_o        <= 5'(len);
                    r_integ_o      <= integ;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_packet_valid  = r_packet_valid;
    assign o_channel       = r_channel_o;
    assign o_continuity    = r_continuity_o;
    assign o_synchronizing = r_sync_o;
    assign o_partial_block = r_partial_o;
    assign o_suffix_kind   = r_kind_o;
    assign o_block_length  = r_len_o;
    assign o_integrity     = r_integ_o;
    assign o_has_data      = r_has_o;
    assign o_byte_index    = r_index_o;
    assign o_block_byte    = r_byte_o;
    assign o_last          = r_last_o;

endmodule

// ===== hw/rtl/npd_checker.sv =====
// npd_checker: port-level checks on the nabts packet decoder result run,
// bound to the top level. Depends on npd_pkg.
module npd_checker
    import npd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_packet_valid,
    input logic [11:0] o_channel,
    input logic [1:0]  o_suffix_kind,
    input logic [4:0]  o_block_length,
    input logic [1:0]  o_integrity,
    input logic        o_has_data,
    input logic [4:0]  o_byte_index,
    input logic [7:0]  o_block_byte,
    input logic        o_last
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_block_byte) && $stable(o_byte_index)
            && $stable(o_last))
        else $error("stalled result changed");

    // within a run the data bytes come in block order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_has_data && !o_last |=>
            !o_out_valid || (o_byte_index == $past(o_byte_index) + 5'd1))
        else $error("byte index skipped");

    // a bad prefix gives one bare result
    a_bad_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_packet_valid |->
            o_last && !o_has_data && o_channel == 12'd0 && o_block_byte == 8'd0)
        else $error("bad prefix result not bare");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_data |-> o_byte_index < o_block_length)
        else $error("byte index beyond block length");

    // only longitudinal suffixes are checked
    a_integ_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_integrity != INTEG_UNCHECKED |->
            o_suffix_kind == SUFFIX_LONG || o_suffix_kind == SUFFIX_LONG_RES)
        else $error("integrity set without longitudinal suffix");

endmodule

bind nabts_packet_decoder npd_checker u_npd_checker (.*);
